### hdl/lookup3_byte_stream_hash_defines.svh
// Assertion macros shared by the lookup3 byte stream hash block.
`ifndef LOOKUP3_BYTE_STREAM_HASH_DEFINES_SVH
`define LOOKUP3_BYTE_STREAM_HASH_DEFINES_SVH

`define L3BSH_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("l3bsh: same-cycle check failed");

`define L3BSH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("l3bsh: next-cycle check failed");

`endif

### hdl/l3bsh_pkg.sv
// Types, constants and round functions of the lookup3 byte stream hash.
package l3bsh_pkg;

   localparam logic [31:0] HASH_INIT = 32'hdeadbeef;
   localparam int BLOCK_BYTES = 12;
   localparam int POS_W = 4;
   localparam int MIX_ROUNDS = 6;
   localparam int FINAL_ROUNDS = 7;
   localparam int STEP_W = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 8;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_MIX = 2'd0;
   localparam kind_type KIND_FINAL = 2'd1;
   localparam kind_type KIND_EMPTY = 2'd2;

   typedef logic [BLOCK_BYTES-1:0][7:0] block_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } words_type;

   typedef struct packed {
      kind_type    kind;
      logic        start;
      logic [31:0] init;
      block_type   block;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [31:0] rotl(logic [31:0] x, logic [4:0] k);
      return (x << k) | (x >> (6'd32 - {1'b0, k}));
   endfunction

   function automatic words_type mix_round(words_type w, logic [STEP_W-1:0] step);
      words_type r;
      r = w;
      case (step)
         3'd0: begin
            r.a = (w.a - w.c) ^ rotl(w.c, 5'd4);
            r.c = w.c + w.b;
         end
         3'd1: begin
            r.b = (w.b - w.a) ^ rotl(w.a, 5'd6);
            r.a = w.a + w.c;
         end
         3'd2: begin
            r.c = (w.c - w.b) ^ rotl(w.b, 5'd8);
            r.b = w.b + w.a;
         end
         3'd3: begin
            r.a = (w.a - w.c) ^ rotl(w.c, 5'd16);
            r.c = w.c + w.b;
         end
         3'd4: begin
            r.b = (w.b - w.a) ^ rotl(w.a, 5'd19);
            r.a = w.a + w.c;
         end
         3'd5: begin
            r.c = (w.c - w.b) ^ rotl(w.b, 5'd4);
            r.b = w.b + w.a;
         end
         default: r = w;
      endcase
      return r;
   endfunction

   function automatic words_type final_round(words_type w, logic [STEP_W-1:0] step);
      words_type r;
      r = w;
      case (step)
         3'd0: r.c = (w.c ^ w.b) - rotl(w.b, 5'd14);
         3'd1: r.a = (w.a ^ w.c) - rotl(w.c, 5'd11);
         3'd2: r.b = (w.b ^ w.a) - rotl(w.a, 5'd25);
         3'd3: r.c = (w.c ^ w.b) - rotl(w.b, 5'd16);
         3'd4: r.a = (w.a ^ w.c) - rotl(w.c, 5'd4);
         3'd5: r.b = (w.b ^ w.a) - rotl(w.a, 5'd14);
         3'd6: r.c = (w.c ^ w.b) - rotl(w.b, 5'd24);
         default: r = w;
      endcase
      return r;
   endfunction

endpackage

### hdl/l3bsh_queue.sv
// Short first-word-fall-through queue of block entries between front and back.
module l3bsh_queue
   import l3bsh_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head_entry,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign status.full = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10: count_in = count_ff + 1'b1;
         2'b01: count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hdl/l3bsh_front.sv
// Front end: accepts byte words, tracks the message and assembles 12-byte blocks.
module l3bsh_front
   import l3bsh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_key_byte,
   input  logic [31:0] req_message_length,
   input  logic [31:0] req_seed,
   output logic        push,
   output entry_type   push_entry
);

   logic [31:0]      rem_ff, rem_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   block_type        blk_ff, blk_in;
   logic             start_ff, start_in;
   logic [31:0]      init_ff, init_in;

   logic             accept;
   logic             idle;
   logic [31:0]      rem_cur;
   logic [31:0]      rem_dec;
   logic [POS_W-1:0] pos_cur;
   block_type        blk_cur;
   logic             start_cur;
   logic [31:0]      init_cur;

   assign accept = req_valid && !req_stall;
   assign idle = (rem_ff == '0);

   always_comb begin
      rem_in = rem_ff;
      pos_in = pos_ff;
      blk_in = blk_ff;
      start_in = start_ff;
      init_in = init_ff;
      push = 1'b0;
      rem_cur = idle ? req_message_length : rem_ff;
      pos_cur = idle ? '0 : pos_ff;
      blk_cur = idle ? '0 : blk_ff;
      start_cur = idle ? 1'b1 : start_ff;
      init_cur = idle ? (HASH_INIT + req_message_length + req_seed) : init_ff;
      blk_cur[pos_cur] = req_key_byte;
      rem_dec = rem_cur - 32'd1;
      push_entry.kind = KIND_MIX;
      push_entry.start = start_cur;
      push_entry.init = init_cur;
      push_entry.block = blk_cur;
      if (accept) begin
         if (idle && (req_message_length == '0)) begin
            push = 1'b1;
            push_entry.kind = KIND_EMPTY;
            push_entry.start = 1'b0;
            push_entry.init = req_seed;
            push_entry.block = '0;
         end else if (rem_dec == '0) begin
            push = 1'b1;
            push_entry.kind = KIND_FINAL;
            rem_in = '0;
            pos_in = '0;
            blk_in = '0;
            start_in = 1'b1;
            init_in = init_cur;
         end else if (pos_cur == POS_W'(BLOCK_BYTES - 1)) begin
            push = 1'b1;
            push_entry.kind = KIND_MIX;
            rem_in = rem_dec;
            pos_in = '0;
            blk_in = '0;
            start_in = 1'b0;
            init_in = init_cur;
         end else begin
            rem_in = rem_dec;
            pos_in = pos_cur + 1'b1;
            blk_in = blk_cur;
            start_in = start_cur;
            init_in = init_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         pos_ff <= '0;
      end else begin
         rem_ff <= rem_in;
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      start_ff <= start_in;
      init_ff <= init_in;
   end

endmodule

### hdl/l3bsh_back.sv
// Back end: iterative mix unit and pipelined final rounds with the result register.
module l3bsh_back
   import l3bsh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  entry_type   head_entry,
   input  logic        head_valid,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value
);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   words_type         st_ff, st_in;

   logic              stg_valid_ff [FINAL_ROUNDS+1];
   logic              stg_valid_in [FINAL_ROUNDS+1];
   logic              stg_raw_ff [FINAL_ROUNDS+1];
   logic              stg_raw_in [FINAL_ROUNDS+1];
   words_type         stg_w_ff [FINAL_ROUNDS+1];
   words_type         stg_w_in [FINAL_ROUNDS+1];

   logic              out_valid_ff, out_valid_in;
   logic [31:0]       out_hash_ff, out_hash_in;

   logic              advance;
   logic              take_final;
   words_type         base;
   words_type         added;

   assign advance = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_hash_value = out_hash_ff;

   always_comb begin
      base = head_entry.start ? words_type'{a: head_entry.init, b: head_entry.init,
                                            c: head_entry.init} : st_ff;
      added.a = base.a + head_entry.block[3:0];
      added.b = base.b + head_entry.block[7:4];
      added.c = base.c + head_entry.block[11:8];
   end

   always_comb begin
      pop = 1'b0;
      take_final = 1'b0;
      if (head_valid && !busy_ff) begin
         case (head_entry.kind)
            KIND_MIX: pop = 1'b1;
            KIND_FINAL, KIND_EMPTY: begin
               pop = advance;
               take_final = advance;
            end
            default: pop = 1'b1;
         endcase
      end
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      st_in = st_ff;
      if (busy_ff) begin
         st_in = mix_round(st_ff, step_ff);
         if (step_ff == STEP_W'(MIX_ROUNDS - 1)) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end else if (pop && (head_entry.kind == KIND_MIX)) begin
         st_in = added;
         busy_in = 1'b1;
         step_in = '0;
      end
   end

   always_comb begin
      for (int k = 0; k <= FINAL_ROUNDS; k++) begin
         stg_valid_in[k] = stg_valid_ff[k];
         stg_raw_in[k] = stg_raw_ff[k];
         stg_w_in[k] = stg_w_ff[k];
      end
      out_valid_in = out_valid_ff;
      out_hash_in = out_hash_ff;
      if (advance) begin
         stg_valid_in[0] = take_final;
         stg_raw_in[0] = (head_entry.kind == KIND_EMPTY);
         stg_w_in[0] = (head_entry.kind == KIND_EMPTY) ?
                       words_type'{a: '0, b: '0, c: head_entry.init} : added;
         for (int k = 1; k <= FINAL_ROUNDS; k++) begin
            stg_valid_in[k] = stg_valid_ff[k-1];
            stg_raw_in[k] = stg_raw_ff[k-1];
            stg_w_in[k] = stg_raw_ff[k-1] ? stg_w_ff[k-1] :
                          final_round(stg_w_ff[k-1], STEP_W'(k - 1));
         end
         out_valid_in = stg_valid_ff[FINAL_ROUNDS];
         out_hash_in = stg_w_ff[FINAL_ROUNDS].c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k <= FINAL_ROUNDS; k++) begin
            stg_valid_ff[k] <= 1'b0;
         end
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         out_valid_ff <= out_valid_in;
         for (int k = 0; k <= FINAL_ROUNDS; k++) begin
            stg_valid_ff[k] <= stg_valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
      out_hash_ff <= out_hash_in;
      for (int k = 0; k <= FINAL_ROUNDS; k++) begin
         stg_raw_ff[k] <= stg_raw_in[k];
         stg_w_ff[k] <= stg_w_in[k];
      end
   end

endmodule

### hdl/lookup3_byte_stream_hash.sv
// Top level of the lookup3 little-endian 32-bit hash over a byte stream.
// The req channel takes one message byte per word. The first word of a message
// also carries the total length and the seed; later words ignore both fields.
// A first word with length zero is an empty message and returns the seed.
// The rsp channel returns one hash word per message after its last byte.
// The front end takes one byte per cycle while req_stall is low and hands each
// 12-byte block to a short queue. The back end runs the six mix rounds of a
// full block one per cycle, so a block is mixed before the next block's bytes
// have arrived. The seven final rounds are pipelined and take a new message
// every cycle unless a block is mixing or the result is held, so short messages
// also flow at one word per cycle. The eight-entry queue takes entries pushed
// while a block is mixing, so req_stall stays low unless the receiver stalls.
// rsp_valid rises once the last byte's entry has passed the queue, final stages
// and result register, later if a block is still mixing ahead of it. While
// rsp_stall and rsp_valid are high, the result register and final pipeline
// hold; the queue fills and req_stall rises once it is full. Synchronous reset
// empties the queue and pipeline and drops any message in progress.
`include "lookup3_byte_stream_hash_defines.svh"

module lookup3_byte_stream_hash
   import l3bsh_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_key_byte,
   input  logic [31:0] req_message_length,
   input  logic [31:0] req_seed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value
);

   logic             q_push;
   logic             q_pop;
   entry_type        q_push_entry;
   entry_type        q_head_entry;
   queue_status_type q_stat;

   assign req_stall = q_stat.full;

   l3bsh_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_key_byte       (req_key_byte),
      .req_message_length (req_message_length),
      .req_seed           (req_seed),
      .push               (q_push),
      .push_entry         (q_push_entry)
   );

   l3bsh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head_entry (q_head_entry),
      .status     (q_stat)
   );

   l3bsh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_entry     (q_head_entry),
      .head_valid     (!q_stat.empty),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

   `L3BSH_ASSERT_SAME(a_no_push_when_full, q_push, !q_stat.full)
   `L3BSH_ASSERT_SAME(a_no_pop_when_empty, q_pop, !q_stat.empty)
   `L3BSH_ASSERT_NEXT(a_push_fills_queue, q_push && !q_pop, !q_stat.empty)

endmodule
